@@ hw/rtl/rde_pkg.sv @@
// Shared types and constants for the radix digit emitter.
package rde_pkg;

  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;
  localparam int COUNT_W  = 7;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 3;
  localparam int CHUNK_W  = 8;
  localparam int ALPHA_N  = 16;

  localparam logic [IDX_W-1:0] REG_RADIX      = 3'd0;
  localparam logic [IDX_W-1:0] REG_ALPHA_LEN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ALPHA_W0   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ALPHA_W1   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ALPHA_W2   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ALPHA_W3   = 3'd5;

  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_RST   = 5'd16;
  localparam logic [4:0] ALEN_RST    = 5'd16;
  localparam logic [4:0] ALEN_MAX    = 5'd16;
  localparam logic [CFG_W-1:0] ALPHA_W0_RST = 32'h33323130;
  localparam logic [CFG_W-1:0] ALPHA_W1_RST = 32'h37363534;
  localparam logic [CFG_W-1:0] ALPHA_W2_RST = 32'h62613938;
  localparam logic [CFG_W-1:0] ALPHA_W3_RST = 32'h66656463;

  // one conversion request handed from front to back
  typedef struct packed {
    logic               error;
    logic [COUNT_W-1:0] count;
  } desc_t;

  typedef enum logic [0:0] {
    F_IDLE,
    F_DIV
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_EMIT,
    B_ERR
  } back_state_t;

endpackage

@@ hw/rtl/rde_front.sv @@
// Front end: classifies a request and divides it into digits, 8 quotient bits per cycle.
module rde_front #(
  parameter int MAX_DIGITS  = 64,
  parameter int VALUE_WIDTH = 64,
  localparam int AW     = $clog2(MAX_DIGITS),
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1),
  localparam int PASSES = (VALUE_WIDTH + rde_pkg::CHUNK_W - 1) / rde_pkg::CHUNK_W,
  localparam int PAD_W  = PASSES * rde_pkg::CHUNK_W,
  localparam int STEP_W = (PASSES > 1) ? $clog2(PASSES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [VALUE_WIDTH-1:0]      value,
  input  logic [4:0]                  radix,
  input  logic [4:0]                  alphabet_length,
  output logic                        busy,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_addr,
  output logic [rde_pkg::DIGIT_W-1:0] mem_data,
  output logic                        push,
  output rde_pkg::desc_t              push_desc
);

  rde_pkg::front_state_t state, state_next;
  logic [PAD_W-1:0]            num, num_next;
  logic [rde_pkg::DIGIT_W-1:0] rem, rem_step;
  logic [STEP_W-1:0]           step;
  logic [CNT_W-1:0]            count, count_inc;
  logic [4:0]                  alen_sat;
  logic                        too_short;
  logic                        last_pass;
  logic                        done;
  logic [rde_pkg::CHUNK_W-1:0] quot;

  assign alen_sat  = (alphabet_length > rde_pkg::ALEN_MAX) ? rde_pkg::ALEN_MAX
                                                           : alphabet_length;
  assign too_short = alen_sat < radix;
  assign last_pass = (step == STEP_W'(PASSES - 1));
  assign count_inc = count + CNT_W'(1);

  // restoring division of one chunk; remainder stays below the radix
  always_comb begin
    logic [rde_pkg::DIGIT_W:0]   t;
    logic [rde_pkg::DIGIT_W-1:0] r;
    logic [rde_pkg::CHUNK_W-1:0] chunk;
    r     = rem;
    chunk = num[PAD_W-1 -: rde_pkg::CHUNK_W];
    quot  = '0;
    for (int j = rde_pkg::CHUNK_W - 1; j >= 0; j--) begin
      t = {r, chunk[j]};
      if (t >= radix) begin
        quot[j] = 1'b1;
        t = t - radix;
      end
      r = t[rde_pkg::DIGIT_W-1:0];
    end
    rem_step = r;
    num_next = PAD_W'({num, quot});
  end

  assign done = last_pass &&
                ((num_next == '0) || (count_inc == CNT_W'(MAX_DIGITS)));

  always_comb begin
    state_next = state;
    unique case (state)
      rde_pkg::F_IDLE: begin
        if (accept && !too_short) state_next = rde_pkg::F_DIV;
      end
      rde_pkg::F_DIV: begin
        if (done) state_next = rde_pkg::F_IDLE;
      end
      default: state_next = rde_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state == rde_pkg::F_DIV);
    mem_we    = (state == rde_pkg::F_DIV) && last_pass;
    mem_addr  = count[AW-1:0];
    mem_data  = rem_step;
    push      = 1'b0;
    push_desc = '0;
    unique case (state)
      rde_pkg::F_IDLE: begin
        if (accept && too_short) begin
          push            = 1'b1;
          push_desc.error = 1'b1;
        end
      end
      rde_pkg::F_DIV: begin
        if (done) begin
          push            = 1'b1;
          push_desc.count = rde_pkg::COUNT_W'(count_inc);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rde_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rde_pkg::F_IDLE) begin
      num   <= PAD_W'(value);
      rem   <= '0;
      step  <= '0;
      count <= '0;
    end else begin
      num <= num_next;
      if (last_pass) begin
        rem   <= '0;
        step  <= '0;
        count <= count_inc;
      end else begin
        rem  <= rem_step;
        step <= step + STEP_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/rde_queue.sv @@
// Two-entry request queue between front and back.
module rde_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rde_pkg::desc_t push_desc,
  input  logic           pop,
  output rde_pkg::desc_t pop_desc,
  output logic           empty,
  output logic           full
);

  rde_pkg::desc_t slots [2];
  logic       wptr, rptr;
  logic [1:0] fill;

  assign empty    = (fill == 2'd0);
  assign full     = (fill == 2'd2);
  assign pop_desc = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      if ((push && !full) && !(pop && !empty)) fill <= fill + 2'd1;
      else if (!(push && !full) && (pop && !empty)) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wptr] <= push_desc;
  end

endmodule

@@ hw/rtl/rde_back.sv @@
// Back end: digit store and character emission, most significant digit first.
module rde_back #(
  parameter int MAX_DIGITS = 64,
  localparam int AW = $clog2(MAX_DIGITS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mem_we,
  input  logic [AW-1:0]               mem_addr,
  input  logic [rde_pkg::DIGIT_W-1:0] mem_data,
  input  logic                        q_empty,
  input  rde_pkg::desc_t              q_desc,
  input  logic [4*rde_pkg::CFG_W-1:0] alphabet,
  output logic                        pop,
  output logic                        busy,
  output logic                        result_valid,
  output logic [rde_pkg::CHAR_W-1:0]  character,
  output logic                        last,
  output logic                        error,
  output logic [rde_pkg::COUNT_W-1:0] digit_count
);

  rde_pkg::back_state_t state, state_next;
  logic [rde_pkg::DIGIT_W-1:0] store [MAX_DIGITS];
  logic [rde_pkg::DIGIT_W-1:0] rd_data;
  logic [AW-1:0]               idx;
  logic [rde_pkg::COUNT_W-1:0] cnt;
  logic                        at_first;

  assign at_first = (idx == '0);
  assign pop      = (state == rde_pkg::B_IDLE) && !q_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      rde_pkg::B_IDLE: begin
        if (!q_empty) state_next = q_desc.error ? rde_pkg::B_ERR : rde_pkg::B_FETCH;
      end
      rde_pkg::B_FETCH: state_next = rde_pkg::B_EMIT;
      rde_pkg::B_EMIT:  state_next = at_first ? rde_pkg::B_IDLE : rde_pkg::B_FETCH;
      rde_pkg::B_ERR:   state_next = rde_pkg::B_IDLE;
      default:          state_next = rde_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != rde_pkg::B_IDLE);
    result_valid = 1'b0;
    character    = '0;
    last         = 1'b0;
    error        = 1'b0;
    digit_count  = '0;
    unique case (state)
      rde_pkg::B_EMIT: begin
        result_valid = 1'b1;
        character    = alphabet[{rd_data, 3'b000} +: rde_pkg::CHAR_W];
        last         = at_first;
        digit_count  = at_first ? cnt : '0;
      end
      rde_pkg::B_ERR: begin
        result_valid = 1'b1;
        last         = 1'b1;
        error        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rde_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx <= AW'(q_desc.count - rde_pkg::COUNT_W'(1));
      cnt <= q_desc.count;
    end else if (state == rde_pkg::B_EMIT && !at_first) begin
      idx <= idx - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_addr] <= mem_data;
    if (state == rde_pkg::B_FETCH) rd_data <= store[idx];
  end

endmodule

@@ hw/rtl/radix_digit_emitter_top.sv @@
// Top level of the radix digit emitter: registers, front, queue and back.
// The divider works through the value in 8-bit chunks for each digit; the emitter then
//   fetches and emits the stored digits one by one, in states B_FETCH and B_EMIT.
// One conversion at a time: busy falls the cycle after the last result.
// Reset (rst, synchronous) restores radix 16 and the alphabet "0123456789abcdef".
// Results cannot be stalled; each shows for one cycle with result_valid.
module radix_digit_emitter_top #(
  parameter int MAX_DIGITS  = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [63:0]                 value,
  input  logic                        wr_en,
  input  logic [rde_pkg::IDX_W-1:0]   wr_index,
  input  logic [rde_pkg::CFG_W-1:0]   wr_data,
  output logic                        result_valid,
  output logic [rde_pkg::CHAR_W-1:0]  character,
  output logic                        last,
  output logic                        error,
  output logic [rde_pkg::COUNT_W-1:0] digit_count
);

  localparam int AW = $clog2(MAX_DIGITS);

  logic [4:0]                  radix;
  logic [4:0]                  alphabet_length;
  logic [rde_pkg::CFG_W-1:0]   alpha_w0, alpha_w1, alpha_w2, alpha_w3;
  logic                        accept;
  logic                        front_busy, back_busy;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [rde_pkg::DIGIT_W-1:0] mem_data;
  logic                        q_push, q_pop, q_empty, q_full;
  rde_pkg::desc_t              push_desc, pop_desc;

  assign busy   = front_busy || !q_empty || back_busy;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix           <= rde_pkg::RADIX_RST;
      alphabet_length <= rde_pkg::ALEN_RST;
      alpha_w0        <= rde_pkg::ALPHA_W0_RST;
      alpha_w1        <= rde_pkg::ALPHA_W1_RST;
      alpha_w2        <= rde_pkg::ALPHA_W2_RST;
      alpha_w3        <= rde_pkg::ALPHA_W3_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        rde_pkg::REG_RADIX:
          radix <= (wr_data[4:0] < rde_pkg::RADIX_MIN) ? rde_pkg::RADIX_MIN : wr_data[4:0];
        rde_pkg::REG_ALPHA_LEN: alphabet_length <= wr_data[4:0];
        rde_pkg::REG_ALPHA_W0:  alpha_w0 <= wr_data;
        rde_pkg::REG_ALPHA_W1:  alpha_w1 <= wr_data;
        rde_pkg::REG_ALPHA_W2:  alpha_w2 <= wr_data;
        rde_pkg::REG_ALPHA_W3:  alpha_w3 <= wr_data;
        default: ;
      endcase
    end
  end

  rde_front #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .value          (value[VALUE_WIDTH-1:0]),
    .radix          (radix),
    .alphabet_length(alphabet_length),
    .busy           (front_busy),
    .mem_we         (mem_we),
    .mem_addr       (mem_addr),
    .mem_data       (mem_data),
    .push           (q_push),
    .push_desc      (push_desc)
  );

  rde_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_desc(push_desc),
    .pop      (q_pop),
    .pop_desc (pop_desc),
    .empty    (q_empty),
    .full     (q_full)
  );

  rde_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_data    (mem_data),
    .q_empty     (q_empty),
    .q_desc      (pop_desc),
    .alphabet    ({alpha_w3, alpha_w2, alpha_w1, alpha_w0}),
    .pop         (q_pop),
    .busy        (back_busy),
    .result_valid(result_valid),
    .character   (character),
    .last        (last),
    .error       (error),
    .digit_count (digit_count)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("busy did not rise after an accepted request");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full)) else $error("request queue overflow");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result emitted while idle");

  a_radix_floor: assert property (@(posedge clk) disable iff (rst)
    radix >= rde_pkg::RADIX_MIN) else $error("radix below two");

endmodule

@@ tb/radix_digit_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the radix digit emitter: predicts each conversion and checks every character.
module radix_digit_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [63:0]                 value,
  input  logic                        wr_en,
  input  logic [rde_pkg::IDX_W-1:0]   wr_index,
  input  logic [rde_pkg::CFG_W-1:0]   wr_data,
  input  logic                        result_valid,
  input  logic [rde_pkg::CHAR_W-1:0]  character,
  input  logic                        last,
  input  logic                        error,
  input  logic [rde_pkg::COUNT_W-1:0] digit_count,
  output int                          mismatch_count,
  output int                          pending
);

  typedef struct {
    logic [rde_pkg::CHAR_W-1:0]  character;
    logic                        last;
    logic                        error;
    logic [rde_pkg::COUNT_W-1:0] count;
  } char_item_t;

  char_item_t                expected_chars[$];
  char_item_t                oldest;
  logic [4:0]                cfg_radix;
  logic [4:0]                cfg_alen;
  logic [rde_pkg::CFG_W-1:0] alpha_word[4];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // divide down and queue alphabet bytes most significant digit first; short alphabet: error item
  function automatic void convert_value(input logic [63:0] v);
    logic [63:0] num;
    logic [3:0]  digits[64];
    logic [3:0]  d;
    int          n;
    int          len;
    char_item_t  item;
    num = v;
    n = 0;
    len = (cfg_alen > rde_pkg::ALEN_MAX) ? int'(rde_pkg::ALEN_MAX) : int'(cfg_alen);
    if (len < int'(cfg_radix)) begin
      item.character = '0;
      item.last = 1'b1;
      item.error = 1'b1;
      item.count = '0;
      expected_chars.push_back(item);
      return;
    end
    if (num == 64'd0) begin
      digits[0] = 4'd0;
      n = 1;
    end else begin
      while (num != 64'd0 && n < 64) begin
        digits[n] = 4'(num % {59'd0, cfg_radix});
        num = num / {59'd0, cfg_radix};
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      d = digits[n-1-k];
      item.character = alpha_word[d[3:2]][d[1:0]*8 +: 8];
      item.last = (k == n - 1);
      item.error = 1'b0;
      item.count = (k == n - 1) ? rde_pkg::COUNT_W'(n) : '0;
      expected_chars.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_radix = rde_pkg::RADIX_RST;
      cfg_alen = rde_pkg::ALEN_RST;
      alpha_word[0] = rde_pkg::ALPHA_W0_RST;
      alpha_word[1] = rde_pkg::ALPHA_W1_RST;
      alpha_word[2] = rde_pkg::ALPHA_W2_RST;
      alpha_word[3] = rde_pkg::ALPHA_W3_RST;
      expected_chars.delete();
      mismatch_count = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          rde_pkg::REG_RADIX: begin
            cfg_radix = (wr_data[4:0] < rde_pkg::RADIX_MIN) ? rde_pkg::RADIX_MIN
                                                            : wr_data[4:0];
          end
          rde_pkg::REG_ALPHA_LEN: cfg_alen = wr_data[4:0];
          rde_pkg::REG_ALPHA_W0:  alpha_word[0] = wr_data;
          rde_pkg::REG_ALPHA_W1:  alpha_word[1] = wr_data;
          rde_pkg::REG_ALPHA_W2:  alpha_word[2] = wr_data;
          rde_pkg::REG_ALPHA_W3:  alpha_word[3] = wr_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        convert_value(value);
      end
      if (result_valid) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf(
            "unexpected result: character %0h last %0b error %0b count %0d",
            character, last, error, digit_count));
        end else begin
          oldest = expected_chars.pop_front();
          if (character !== oldest.character)
            report_mismatch($sformatf("character: expected %0h, got %0h",
                                      oldest.character, character));
          if (last !== oldest.last)
            report_mismatch($sformatf("last: expected %0b, got %0b", oldest.last, last));
          if (error !== oldest.error)
            report_mismatch($sformatf("error: expected %0b, got %0b", oldest.error, error));
          if (digit_count !== oldest.count)
            report_mismatch($sformatf("digit_count: expected %0d, got %0d",
                                      oldest.count, digit_count));
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the radix digit emitter: clock, reset, requests, register writes, verdict.
module tb;

  localparam int WATCHDOG_LIMIT = 5000;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [63:0]                 value;
  logic                        wr_en;
  logic [rde_pkg::IDX_W-1:0]   wr_index;
  logic [rde_pkg::CFG_W-1:0]   wr_data;
  logic                        result_valid;
  logic [rde_pkg::CHAR_W-1:0]  character;
  logic                        last;
  logic                        error;
  logic [rde_pkg::COUNT_W-1:0] digit_count;
  int                          mismatch_count;
  int                          pending;
  bit                          gaps_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  radix_digit_emitter_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .result_valid (result_valid),
    .character    (character),
    .last         (last),
    .error        (error),
    .digit_count  (digit_count)
  );

  radix_digit_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .value          (value),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .result_valid   (result_valid),
    .character      (character),
    .last           (last),
    .error          (error),
    .digit_count    (digit_count),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // start may drop at random while waiting; the request goes in when start && !busy
  task automatic send_value(input logic [63:0] v);
    bit hit;
    value <= v;
    start <= !(gaps_on && $urandom_range(99) < 38);
    do begin
      @(posedge clk);
      hit = start && !busy;
      if (!hit) start <= !(gaps_on && $urandom_range(99) < 38);
    end while (!hit);
  endtask

  // hold off until every queued character has come out and the block is idle
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [rde_pkg::IDX_W-1:0] idx,
                           input logic [rde_pkg::CFG_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
  endtask

  task automatic close_writes();
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // mostly short values of up to 16 bits; one in ten is 41 to 64 bits wide
  function automatic logic [63:0] rand_value();
    int          w;
    int          pick;
    logic [63:0] v;
    pick = $urandom_range(9);
    if (pick < 7) w = $urandom_range(16, 1);
    else if (pick < 9) w = $urandom_range(40, 17);
    else w = $urandom_range(64, 41);
    v = {$urandom, $urandom};
    if ($urandom_range(9) == 0) v = '1;
    if ($urandom_range(19) == 0) v = '0;
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  task automatic random_setup();
    logic [4:0] r;
    logic [4:0] eff;
    logic [4:0] alen;
    if ($urandom_range(4) == 0) r = 5'($urandom_range(31, 0));
    else r = 5'($urandom_range(16, 2));
    eff = (r < rde_pkg::RADIX_MIN) ? rde_pkg::RADIX_MIN : r;
    if ($urandom_range(6) == 0 || eff > rde_pkg::ALEN_MAX) alen = 5'($urandom_range(31, 0));
    else alen = 5'($urandom_range(31, eff));
    write_reg(rde_pkg::REG_RADIX, {27'($urandom), r});
    write_reg(rde_pkg::REG_ALPHA_LEN, {27'($urandom), alen});
    if ($urandom_range(3) == 0) begin
      write_reg(rde_pkg::REG_ALPHA_W0, rde_pkg::ALPHA_W0_RST);
      write_reg(rde_pkg::REG_ALPHA_W1, rde_pkg::ALPHA_W1_RST);
      write_reg(rde_pkg::REG_ALPHA_W2, rde_pkg::ALPHA_W2_RST);
      write_reg(rde_pkg::REG_ALPHA_W3, rde_pkg::ALPHA_W3_RST);
    end else begin
      write_reg(rde_pkg::REG_ALPHA_W0, $urandom);
      write_reg(rde_pkg::REG_ALPHA_W1, $urandom);
      write_reg(rde_pkg::REG_ALPHA_W2, $urandom);
      write_reg(rde_pkg::REG_ALPHA_W3, $urandom);
    end
    close_writes();
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || result_valid || wr_en) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    value <= '0;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    gaps_on = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset alphabet and radix 16
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h0123_4567_89AB_CDEF);

    // radix written as zero saturates to two: 64 digit conversion
    settle();
    write_reg(rde_pkg::REG_RADIX, 32'd0);
    write_reg(rde_pkg::REG_ALPHA_LEN, 32'd2);
    write_reg(rde_pkg::REG_ALPHA_W0, 32'hFFFF_FFFF);
    close_writes();
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'd0);
    send_value(64'h8000_0000_0000_0000);
    settle();
    write_reg(rde_pkg::REG_RADIX, 32'd1);
    close_writes();
    send_value(64'd5);

    // radix above sixteen never fits the alphabet
    settle();
    write_reg(rde_pkg::REG_ALPHA_LEN, 32'd16);
    write_reg(rde_pkg::REG_RADIX, 32'd17);
    close_writes();
    send_value(64'd42);
    settle();
    write_reg(rde_pkg::REG_RADIX, 32'hFFFF_FFFF);
    close_writes();
    send_value(64'hFFFF_FFFF_FFFF_FFFF);

    // missing alphabet and alphabet one short of the radix
    settle();
    write_reg(rde_pkg::REG_RADIX, 32'd16);
    write_reg(rde_pkg::REG_ALPHA_LEN, 32'd0);
    close_writes();
    send_value(64'd7);
    settle();
    write_reg(rde_pkg::REG_ALPHA_LEN, 32'd15);
    close_writes();
    send_value(64'd255);

    // alphabet length above sixteen counts as sixteen
    settle();
    write_reg(rde_pkg::REG_RADIX, 32'd10);
    write_reg(rde_pkg::REG_ALPHA_LEN, 32'd31);
    write_reg(rde_pkg::REG_ALPHA_W0, 32'h0000_0000);
    write_reg(rde_pkg::REG_ALPHA_W1, 32'hFFFF_FFFF);
    write_reg(rde_pkg::REG_ALPHA_W2, 32'hA5C3_0F96);
    write_reg(rde_pkg::REG_ALPHA_W3, 32'hFFFF_FFFF);
    close_writes();
    send_value(64'd0);
    send_value(64'd10000000000000000000);
    send_value(64'd9);

    // writes to unused indexes leave the setup alone
    settle();
    write_reg(rde_pkg::REG_RADIX, 32'd3);
    write_reg(rde_pkg::REG_ALPHA_LEN, 32'd3);
    write_reg(rde_pkg::REG_ALPHA_W0, 32'h5A3C_E17B);
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'hFFFF_FFFF);
    close_writes();
    send_value(64'd2);
    send_value(64'd3);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);

    // length exactly at the radix and one below
    settle();
    write_reg(rde_pkg::REG_RADIX, 32'd7);
    write_reg(rde_pkg::REG_ALPHA_LEN, 32'd6);
    close_writes();
    send_value(64'd48);
    settle();
    write_reg(rde_pkg::REG_ALPHA_LEN, 32'd7);
    close_writes();
    send_value(64'd48);

    for (int p = 0; p < 10; p++) begin
      settle();
      random_setup();
      gaps_on = (p != 3);
      for (int i = 0; i < 40; i++) begin
        if (i == 20 && p % 3 == 0) settle();
        send_value(rand_value());
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ radix_digit_emitter_top.f @@
hw/rtl/rde_pkg.sv
hw/rtl/rde_front.sv
hw/rtl/rde_queue.sv
hw/rtl/rde_back.sv
hw/rtl/radix_digit_emitter_top.sv
tb/radix_digit_checker.sv
tb/tb.sv
